>>> design/brb_pkg.sv
// Shared constants and control/status types for the circular byte FIFO.
package brb_pkg;

  // Default geometry
  localparam int BRB_DEPTH     = 1024;
  localparam int BRB_MAX_BURST = 64;

  // Field widths
  localparam int MODE_W = 3;
  localparam int LEN_W  = 11;
  localparam int DATA_W = 8;

  // Command codes carried in the mode field
  localparam logic [MODE_W-1:0] MODE_WR_HDR  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WR_DATA = 3'd1;
  localparam logic [MODE_W-1:0] MODE_READ    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PEEK    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;

  // Result kind codes
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_BYTE   = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;       // take the input request and update the ring state
    logic load_status;  // load the single status result into the output register
    logic issue;        // read the next burst byte from storage
    logic load_byte;    // move the fetched byte into the output register
  } brb_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic burst;        // the pending request produces data byte results
    logic issue_more;   // burst bytes still to fetch
    logic deliv_last;   // next byte delivered ends the burst
  } brb_stat_t;

endpackage

>>> design/brb_ctrl.sv
// Controller state machine: request acceptance, burst fetch and output valid.
module brb_ctrl
  import brb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  brb_stat_t stat,
  output brb_cmd_t  cmd
);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_BURST = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic q_valid_r, q_valid_nxt;
  logic out_free;
  logic accept;

  // Output slot can take a new result this cycle
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  // Command decode and next state
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cmd.accept    = accept;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (stat.burst) begin
            state_nxt = S_BURST;
          end else begin
            cmd.load_status = 1'b1;
          end
        end
      end
      S_BURST: begin
        cmd.load_byte = q_valid_r && out_free;
        cmd.issue     = stat.issue_more && (!q_valid_r || cmd.load_byte);
        if (cmd.load_byte && stat.deliv_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    q_valid_nxt   = cmd.issue || (q_valid_r && !cmd.load_byte);
    out_valid_nxt = cmd.load_status || cmd.load_byte || (out_valid_r && !out_tready);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      q_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      q_valid_r   <= q_valid_nxt;
    end
  end

endmodule

>>> design/brb_dpath.sv
// Datapath: byte storage, ring pointers, fill level, burst counters and result register.
module brb_dpath
  import brb_pkg::*;
#(
  parameter int DEPTH     = BRB_DEPTH,
  parameter int MAX_BURST = BRB_MAX_BURST
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [LEN_W-1:0]  in_length,
  input  logic [DATA_W-1:0] in_data,
  input  brb_cmd_t          cmd,
  output brb_stat_t         stat,
  output logic              out_kind,
  output logic [DATA_W-1:0] out_data,
  output logic              out_ok,
  output logic [LEN_W-1:0]  out_count,
  output logic              out_last,
  output logic [LEN_W-1:0]  out_fill
);

  localparam int CW = $clog2(DEPTH + 1);            // fill level
  localparam int PW = $clog2(DEPTH);                // ring index
  localparam int WW = (CW > LEN_W) ? CW : LEN_W;    // compare width
  localparam int SW = CW + 1;                       // pointer sum
  localparam int BW = $clog2(MAX_BURST + 1);        // burst length

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] mem_q_r;

  logic [PW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;
  logic [LEN_W-1:0] wrem_r, wrem_nxt;
  logic             wadm_r, wadm_nxt;
  logic [PW-1:0]    rd_ptr_r;
  logic [BW-1:0]    issue_cnt_r, deliv_cnt_r, burst_n_r;
  logic [LEN_W-1:0] burst_fill_r;

  logic              kind_r, ok_r, last_r;
  logic [DATA_W-1:0] data_r;
  logic [LEN_W-1:0]  count_r, ofill_r;

  logic [WW-1:0]    fill_w, free_w, fill_nxt_w;
  logic [BW-1:0]    want, n_rd, burst_n;
  logic [SW-1:0]    tail_sum, head_sum;
  logic [PW-1:0]    tail;
  logic             mem_we;
  logic             st_ok;
  logic [LEN_W-1:0] st_cnt;
  logic             burst;

  assign fill_w = WW'(fill_r);
  assign free_w = WW'(DEPTH) - fill_w;

  // Clamp the requested burst and limit a read to what is held
  assign want = (in_length < LEN_W'(MAX_BURST)) ? BW'(in_length) : BW'(MAX_BURST);
  assign n_rd = (WW'(want) < fill_w) ? want : BW'(fill_w);

  // Tail index: head plus fill, one wrap at most
  assign tail_sum = SW'(head_r) + SW'(fill_r);
  assign tail = (tail_sum >= SW'(DEPTH)) ? PW'(tail_sum - SW'(DEPTH)) : PW'(tail_sum);

  // Head after consuming a read burst
  assign head_sum = SW'(head_r) + SW'(n_rd);

  // Request decode and next ring state
  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    wrem_nxt = wrem_r;
    wadm_nxt = wadm_r;
    mem_we   = 1'b0;
    st_ok    = 1'b0;
    st_cnt   = '0;
    burst    = 1'b0;
    burst_n  = n_rd;
    case (in_mode)
      MODE_WR_HDR: begin
        if (WW'(in_length) <= free_w) begin
          wadm_nxt = (in_length != '0);
          wrem_nxt = in_length;
          st_ok    = 1'b1;
          st_cnt   = in_length;
        end else begin
          wadm_nxt = 1'b0;
          wrem_nxt = '0;
        end
      end
      MODE_WR_DATA: begin
        if (wadm_r && (wrem_r != '0) && (fill_r != CW'(DEPTH))) begin
          mem_we   = 1'b1;
          fill_nxt = fill_r + CW'(1);
          wrem_nxt = wrem_r - LEN_W'(1);
          wadm_nxt = (wrem_nxt != '0);
          st_ok    = 1'b1;
          st_cnt   = LEN_W'(1);
        end else begin
          wadm_nxt = 1'b0;
          wrem_nxt = '0;
        end
      end
      MODE_READ: begin
        st_ok = 1'b1;
        if (n_rd != '0) begin
          burst    = 1'b1;
          fill_nxt = fill_r - CW'(n_rd);
          if (fill_nxt == '0) begin
            head_nxt = '0;
          end else if (head_sum >= SW'(DEPTH)) begin
            head_nxt = PW'(head_sum - SW'(DEPTH));
          end else begin
            head_nxt = PW'(head_sum);
          end
        end
      end
      MODE_PEEK: begin
        burst_n = want;
        if (fill_w >= WW'(want)) begin
          st_ok = 1'b1;
          burst = (want != '0);
        end
      end
      MODE_CLEAR: begin
        head_nxt = '0;
        fill_nxt = '0;
        wrem_nxt = '0;
        wadm_nxt = 1'b0;
        st_ok    = 1'b1;
      end
      default: begin
        st_ok = 1'b0;
      end
    endcase
  end

  assign fill_nxt_w = WW'(fill_nxt);

  assign stat.burst      = burst;
  assign stat.issue_more = (issue_cnt_r != '0);
  assign stat.deliv_last = (deliv_cnt_r == BW'(1));

  // Ring state and burst counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      fill_r      <= '0;
      wrem_r      <= '0;
      wadm_r      <= 1'b0;
      issue_cnt_r <= '0;
      deliv_cnt_r <= '0;
    end else begin
      if (cmd.accept) begin
        head_r <= head_nxt;
        fill_r <= fill_nxt;
        wrem_r <= wrem_nxt;
        wadm_r <= wadm_nxt;
        if (burst) begin
          issue_cnt_r <= burst_n;
          deliv_cnt_r <= burst_n;
        end
      end
      if (cmd.issue) begin
        issue_cnt_r <= issue_cnt_r - BW'(1);
      end
      if (cmd.load_byte) begin
        deliv_cnt_r <= deliv_cnt_r - BW'(1);
      end
    end
  end

  // Burst payload, read pointer and result register
  always_ff @(posedge clk) begin
    if (cmd.accept && burst) begin
      rd_ptr_r     <= head_r;
      burst_n_r    <= burst_n;
      burst_fill_r <= fill_nxt_w[LEN_W-1:0];
    end else if (cmd.issue) begin
      rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (cmd.load_status) begin
      kind_r  <= KIND_STATUS;
      data_r  <= '0;
      ok_r    <= st_ok;
      count_r <= st_cnt;
      last_r  <= 1'b1;
      ofill_r <= fill_nxt_w[LEN_W-1:0];
    end else if (cmd.load_byte) begin
      kind_r  <= KIND_BYTE;
      data_r  <= mem_q_r;
      ok_r    <= 1'b1;
      count_r <= LEN_W'(burst_n_r);
      last_r  <= stat.deliv_last;
      ofill_r <= burst_fill_r;
    end
  end

  // Byte storage: one write port at the tail, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.accept && mem_we) begin
      mem[tail] <= in_data;
    end
    if (cmd.issue) begin
      mem_q_r <= mem[rd_ptr_r];
    end
  end

  assign out_kind  = kind_r;
  assign out_data  = data_r;
  assign out_ok    = ok_r;
  assign out_count = count_r;
  assign out_last  = last_r;
  assign out_fill  = ofill_r;

endmodule

>>> design/byte_ring_buffer_bursts.sv
// Top level of the circular byte FIFO with burst read, peek and message write commands.
//
// Usage: requests enter on the in_ stream (in_tuser carries the command code,
// in_tdata the length and the byte), results leave on the out_ stream.
// A message write is a header request, admitted whole or refused, followed by
// one write-data request per byte. A read that finds bytes, or a peek that finds all
// it asks for, returns them as a run of data results, the final one flagged by
// out_tlast; every other request returns one status result, always with out_tlast high.
// A status result is registered and shown in the cycle after its request is taken.
// A burst fetches each byte through the registered storage read port and then the
// output register and, once the first byte is out, delivers one byte per cycle while the
// receiver does not stall; the next request is taken only once the last byte is loaded.
// One request is worked on at a time: in_tready is high only with no burst in
// flight and the output register free or being emptied in that cycle.
// When the receiver stalls, the output register holds its result and the
// burst fetch pauses; nothing is dropped.
// Reset empties the ring, drops any unfinished message and clears out_tvalid;
// the byte storage itself is not cleared.
module byte_ring_buffer_bursts
  import brb_pkg::*;
#(
  parameter int DEPTH     = BRB_DEPTH,
  parameter int MAX_BURST = BRB_MAX_BURST
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // length[10:0], data[18:11], zero[23:19]
  input  logic [2:0]  in_tuser,    // mode[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // data_out[7:0], ok[8], count[19:9], fill[30:20], zero[31]
  output logic        out_tlast,
  output logic [0:0]  out_tuser    // kind[0]
);

  brb_cmd_t          cmd;
  brb_stat_t         stat;
  logic              kind;
  logic [DATA_W-1:0] data_out;
  logic              ok;
  logic [LEN_W-1:0]  count;
  logic [LEN_W-1:0]  fill;

  // Sequencing
  brb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Storage and arithmetic
  brb_dpath #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mode   (in_tuser),
    .in_length (in_tdata[10:0]),
    .in_data   (in_tdata[18:11]),
    .cmd       (cmd),
    .stat      (stat),
    .out_kind  (kind),
    .out_data  (data_out),
    .out_ok    (ok),
    .out_count (count),
    .out_last  (out_tlast),
    .out_fill  (fill)
  );

  // Result packing
  assign out_tdata = {1'b0, fill, count, ok, data_out};
  assign out_tuser = kind;

endmodule

>>> design/brb_chk.sv
// Port-level checker for the circular byte FIFO, bound to the top level.
module brb_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast,
  input logic [0:0]  out_tuser
);

  // A stalled result stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload
  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast)
                                  && $stable(out_tuser))
    else $error("result payload changed while stalled");

  // A status result is always the end of its request
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] == 1'b0) |-> out_tlast && (out_tdata[7:0] == 8'd0))
    else $error("status result without last or with nonzero byte");

  // A data byte carries ok and a nonzero run length
  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[8] && (out_tdata[19:9] != 11'd0))
    else $error("data byte result with bad ok or count");

endmodule

bind byte_ring_buffer_bursts brb_chk u_brb_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

>>> bench/byte_ring_buffer_bursts_tb.sv
// Self-checking testbench for the circular byte FIFO with burst read, peek and message writes.
`timescale 1ns / 100ps

module byte_ring_buffer_bursts_tb;
  import brb_pkg::*;

  localparam int DEPTH       = BRB_DEPTH;
  localparam int MAX_BURST   = BRB_MAX_BURST;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 40;

  // One result as seen on the out_ stream
  typedef struct packed {
    logic        kind;
    logic [7:0]  data_out;
    logic        ok;
    logic [10:0] count;
    logic        last;
    logic [10:0] fill;
  } ring_result_t;

  // Ring model plus the queue of results still owed by the block
  class ring_scoreboard;
    logic [7:0]   ring [DEPTH];
    int           head;
    int           fill;
    int           wr_left;
    bit           wr_open;
    ring_result_t owed [$];
    int           errors;

    function new();
      head    = 0;
      fill    = 0;
      wr_left = 0;
      wr_open = 0;
      errors  = 0;
      foreach (ring[i]) ring[i] = '0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void owe(logic kind, logic [7:0] dout, logic ok, int count, logic last);
      ring_result_t r;
      r.kind     = kind;
      r.data_out = dout;
      r.ok       = ok;
      r.count    = count[10:0];
      r.last     = last;
      r.fill     = fill[10:0];
      owed.push_back(r);
    endfunction

    // Work out the results of one accepted request and update the ring
    function void note_request(logic [2:0] mode, logic [10:0] len, logic [7:0] din);
      int l;
      int want;
      int n;
      l    = int'(len);
      want = (l < MAX_BURST) ? l : MAX_BURST;
      case (mode)
        MODE_WR_HDR: begin
          if (l <= DEPTH - fill) begin
            wr_open = (l != 0);
            wr_left = l;
            owe(KIND_STATUS, 8'h00, 1'b1, l, 1'b1);
          end else begin
            wr_open = 0;
            wr_left = 0;
            owe(KIND_STATUS, 8'h00, 1'b0, 0, 1'b1);
          end
        end
        MODE_WR_DATA: begin
          if (wr_open && wr_left != 0 && fill < DEPTH) begin
            ring[(head + fill) % DEPTH] = din;
            fill++;
            wr_left--;
            if (wr_left == 0) wr_open = 0;
            owe(KIND_STATUS, 8'h00, 1'b1, 1, 1'b1);
          end else begin
            // stray byte: dropped, and anything half-open is closed
            wr_open = 0;
            wr_left = 0;
            owe(KIND_STATUS, 8'h00, 1'b0, 0, 1'b1);
          end
        end
        MODE_READ: begin
          n = (want < fill) ? want : fill;
          if (n == 0) begin
            owe(KIND_STATUS, 8'h00, 1'b1, 0, 1'b1);
          end else begin
            // fill reported is the level after the bytes are consumed
            fill -= n;
            for (int i = 0; i < n; i++)
              owe(KIND_BYTE, ring[(head + i) % DEPTH], 1'b1, n, i == n - 1);
            head = (head + n) % DEPTH;
            if (fill == 0) head = 0;
          end
        end
        MODE_PEEK: begin
          if (fill < want) begin
            owe(KIND_STATUS, 8'h00, 1'b0, 0, 1'b1);
          end else if (want == 0) begin
            owe(KIND_STATUS, 8'h00, 1'b1, 0, 1'b1);
          end else begin
            for (int i = 0; i < want; i++)
              owe(KIND_BYTE, ring[(head + i) % DEPTH], 1'b1, want, i == want - 1);
          end
        end
        MODE_CLEAR: begin
          head    = 0;
          fill    = 0;
          wr_left = 0;
          wr_open = 0;
          owe(KIND_STATUS, 8'h00, 1'b1, 0, 1'b1);
        end
        default: begin
          owe(KIND_STATUS, 8'h00, 1'b0, 0, 1'b1);
        end
      endcase
    endfunction

    function void cmp(string what, int e, int g);
      if (e != g) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, e, g);
        errors++;
      end
    endfunction

    // Compare one accepted result with the oldest one owed
    function void check_result(ring_result_t got);
      ring_result_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      e = owed.pop_front();
      cmp("kind", e.kind, got.kind);
      cmp("data_out", e.data_out, got.data_out);
      cmp("ok", e.ok, got.ok);
      cmp("count", e.count, got.count);
      cmp("last", e.last, got.last);
      cmp("fill", e.fill, got.fill);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;    // length[10:0], data[18:11], zero[23:19]
  logic [2:0]  in_tuser;    // mode[2:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;   // data_out[7:0], ok[8], count[19:9], fill[30:20], zero[31]
  logic        out_tlast;
  logic [0:0]  out_tuser;   // kind[0]

  ring_scoreboard sb;
  int  src_idle_pct;
  int  snk_idle_pct;
  int  items_sent;
  int  cycles;
  bit  hold_req;

  byte_ring_buffer_bursts u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("byte_ring_buffer_bursts_tb: done, errors");
    $finish;
  end

  // Receiver: take results, check them, and stall at random or on a long hold
  initial begin : receiver
    ring_result_t got;
    int hold_left;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.kind     = out_tuser[0];
        got.data_out = out_tdata[7:0];
        got.ok       = out_tdata[8];
        got.count    = out_tdata[19:9];
        got.last     = out_tlast;
        got.fill     = out_tdata[30:20];
        sb.check_result(got);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Offer one request and wait until the block takes it
  task automatic send_req(logic [2:0] mode, logic [10:0] len, logic [7:0] din);
    if ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {5'b0, din, len};
    do @(posedge clk); while (!in_tready);
    sb.note_request(mode, len, din);
    items_sent++;
  endtask

  // Header followed by some or all of its bytes, or by more bytes than it admits
  task automatic send_message(int len, int sent);
    send_req(MODE_WR_HDR, len[10:0], 8'($urandom_range(255)));
    for (int i = 0; i < sent; i++)
      send_req(MODE_WR_DATA, 11'($urandom_range(2047)), 8'($urandom_range(255)));
  endtask

  function automatic logic [10:0] pick_len();
    return ($urandom_range(4) == 0) ? 11'($urandom_range(2047)) : 11'($urandom_range(70));
  endfunction

  // One random unit of work, mostly well-formed messages and bursts
  task automatic random_action();
    int pick;
    int len;
    int cut;
    pick = $urandom_range(99);
    if (pick < 40) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 80) : $urandom_range(12);
      cut = ($urandom_range(9) == 0) ? $urandom_range(len) : len;
      send_message(len, cut);
    end else if (pick < 60) begin
      send_req(MODE_READ, pick_len(), 8'($urandom_range(255)));
    end else if (pick < 75) begin
      send_req(MODE_PEEK, pick_len(), 8'($urandom_range(255)));
    end else if (pick < 80) begin
      send_req(MODE_CLEAR, 11'($urandom_range(2047)), 8'($urandom_range(255)));
    end else if (pick < 85) begin
      send_req(MODE_CLEAR + 3'($urandom_range(1, 3)), 11'($urandom_range(2047)),
               8'($urandom_range(255)));
    end else if (pick < 93) begin
      send_req(MODE_WR_DATA, 11'($urandom_range(2047)), 8'($urandom_range(255)));
    end else begin
      send_req(MODE_WR_HDR, 11'($urandom_range(2047)), 8'($urandom_range(255)));
    end
  endtask

  task automatic random_phase();
    int target;
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) random_action();
  endtask

  // Main sequence
  initial begin : main
    sb           = new();
    src_idle_pct = 6;
    snk_idle_pct = 64;
    items_sent   = 0;
    hold_req     = 1'b0;
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    in_tuser     <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-ring cases
    send_req(MODE_READ, 11'd5, 8'h00);
    send_req(MODE_PEEK, 11'd0, 8'h00);
    send_req(MODE_PEEK, 11'd1, 8'h00);
    send_req(MODE_WR_DATA, 11'd0, 8'hFF);
    send_message(0, 1);                  // zero-length message, then a stray byte
    send_req(MODE_WR_HDR, 11'd1025, 8'h00);
    send_req(MODE_WR_HDR, 11'd2047, 8'hFF);
    // Directed: short message, peeks, abandoned remainder
    send_req(MODE_WR_HDR, 11'd4, 8'h00);
    send_req(MODE_WR_DATA, 11'd0, 8'h00);
    send_req(MODE_WR_DATA, 11'd2047, 8'hFF);
    send_req(MODE_WR_DATA, 11'd0, 8'hA5);
    send_req(MODE_WR_DATA, 11'd0, 8'h5A);
    send_req(MODE_PEEK, 11'd4, 8'h00);
    send_req(MODE_PEEK, 11'd5, 8'h00);
    send_message(3, 2);
    send_message(2, 2);
    // Clamped read empties the ring and rewinds the head
    send_req(MODE_READ, 11'd2047, 8'h00);
    send_req(MODE_CLEAR + 3'd1, 11'd0, 8'h00);
    send_req(MODE_CLEAR + 3'd2, 11'd2047, 8'hFF);
    send_req(MODE_CLEAR + 3'd3, 11'd1024, 8'h00);
    send_message(2, 1);
    send_req(MODE_CLEAR, 11'd0, 8'h00);
    send_req(MODE_WR_DATA, 11'd0, 8'h88);
    send_req(MODE_WR_HDR, 11'd1024, 8'h00);

    // Random, receiver mostly idle; starts with a long hold so the block backs up
    hold_req = 1'b1;
    random_phase();
    // Sender pauses until everything owed has arrived
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);

    src_idle_pct = 64;
    snk_idle_pct = 6;
    random_phase();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    random_phase();

    // Last message, zero and one byte headers, an oversized peek, then drain the ring
    send_req(MODE_CLEAR, 11'd0, 8'h00);
    send_message(16, 16);
    send_req(MODE_WR_HDR, 11'd0, 8'h00);
    send_req(MODE_WR_HDR, 11'd1, 8'h00);
    send_req(MODE_WR_DATA, 11'd0, 8'hC3);
    send_req(MODE_PEEK, 11'd2047, 8'h00);
    while (sb.fill > 0) send_req(MODE_READ, 11'($urandom_range(40, 2047)), 8'h00);

    // Drain and finish
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("byte_ring_buffer_bursts_tb: done, clean");
    end else begin
      $display("byte_ring_buffer_bursts_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
design/brb_pkg.sv
design/brb_ctrl.sv
design/brb_dpath.sv
design/byte_ring_buffer_bursts.sv
design/brb_chk.sv
bench/byte_ring_buffer_bursts_tb.sv
